// ----- rtl/core/ssrs_pkg.sv -----
package ssrs_pkg;

    localparam int MAX_SAMPLES = 128;
    localparam int VAL_W       = 24;
    localparam int RANK_W      = 8;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int RCNT_W      = (CNT_W > RANK_W) ? CNT_W : RANK_W;
    localparam int SUM_W       = VAL_W + CNT_W;
    localparam int SQ_W        = 2 * VAL_W;
    localparam int S2_W        = SQ_W + CNT_W;
    localparam int DIV_W       = S2_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int SQRT_CNT_W  = $clog2(VAL_W + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DATA_W  = RANK_W + 3 * VAL_W;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic             op;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_MLOAD,
        ST_MCAND,
        ST_MSCAN,
        ST_DIV1,
        ST_DIV1W,
        ST_SCAN2,
        ST_DIV2,
        ST_DIV2W,
        ST_CMP,
        ST_CMP2,
        ST_SQRT,
        ST_SQRTW,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/core/ssrs_front.sv -----
module ssrs_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ssrs_pkg::VAL_W-1:0]        s_axis_tdata,  // sample_value
    input  logic                              s_axis_tuser,  // opcode
    output logic                              q_valid,
    input  logic                              q_ready,
    output ssrs_pkg::entry_t                  q_entry
);

    ssrs_pkg::entry_t                 queue_reg [ssrs_pkg::QUEUE_DEPTH];
    logic [ssrs_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ssrs_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ssrs_pkg::QCNT_W-1:0]      fill_reg, fill_next;
    logic [ssrs_pkg::CNT_W-1:0]       load_reg, load_next;
    logic                             accept, push, pop;

    assign s_axis_tready = (fill_reg != ssrs_pkg::QCNT_W'(ssrs_pkg::QUEUE_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    // drop adds once the set is full
    assign push          = accept && ((s_axis_tuser == ssrs_pkg::OP_FINISH) ||
                           (load_reg < ssrs_pkg::CNT_W'(ssrs_pkg::MAX_SAMPLES)));
    assign q_valid       = (fill_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_entry       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + ssrs_pkg::QCNT_W'(push) - ssrs_pkg::QCNT_W'(pop);
        load_next   = load_reg;
        if (push) begin
            if (s_axis_tuser == ssrs_pkg::OP_FINISH) begin
                load_next = '0;
            end else begin
                load_next = load_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            load_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            load_reg   <= load_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg].op    <= s_axis_tuser;
            queue_reg[wr_ptr_reg].value <= s_axis_tdata;
        end
    end

endmodule

// ----- rtl/core/ssrs_div.sv -----
module ssrs_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ssrs_pkg::DIV_W-1:0]    dividend,
    input  logic [ssrs_pkg::CNT_W-1:0]    divisor,
    output logic                          done,
    output logic [ssrs_pkg::DIV_W-1:0]    quotient,
    output logic [ssrs_pkg::CNT_W-1:0]    remainder
);

    logic [ssrs_pkg::DIV_W-1:0]     quo_reg;
    logic [ssrs_pkg::CNT_W-1:0]     rem_reg;
    logic [ssrs_pkg::CNT_W-1:0]     dsr_reg;
    logic [ssrs_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg, done_reg;
    logic [ssrs_pkg::CNT_W:0]       r_sh, r_sub;
    logic                           fits;

    assign r_sh  = {rem_reg, quo_reg[ssrs_pkg::DIV_W-1]};
    assign fits  = (r_sh >= {1'b0, dsr_reg});
    assign r_sub = r_sh - {1'b0, dsr_reg};

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ssrs_pkg::DIV_CNT_W'(ssrs_pkg::DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ssrs_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[ssrs_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? r_sub[ssrs_pkg::CNT_W-1:0] : r_sh[ssrs_pkg::CNT_W-1:0];
        end
    end

endmodule

// ----- rtl/core/ssrs_sqrt.sv -----
module ssrs_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ssrs_pkg::SQ_W-1:0]     radicand,
    output logic                          done,
    output logic [ssrs_pkg::VAL_W-1:0]    root
);

    logic [ssrs_pkg::SQ_W-1:0]       x_reg;
    logic [ssrs_pkg::VAL_W:0]        rem_reg;
    logic [ssrs_pkg::VAL_W-1:0]      root_reg;
    logic [ssrs_pkg::SQRT_CNT_W-1:0] cnt_reg;
    logic                            busy_reg, done_reg;
    logic [ssrs_pkg::VAL_W+2:0]      r_sh, trial, r_sub;
    logic                            fits;

    // two radicand bits per step
    assign r_sh  = {rem_reg, x_reg[ssrs_pkg::SQ_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign fits  = (r_sh >= trial);
    assign r_sub = r_sh - trial;

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ssrs_pkg::SQRT_CNT_W'(ssrs_pkg::VAL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ssrs_pkg::SQRT_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[ssrs_pkg::SQ_W-3:0], 2'b00};
            rem_reg  <= fits ? r_sub[ssrs_pkg::VAL_W:0] : r_sh[ssrs_pkg::VAL_W:0];
            root_reg <= {root_reg[ssrs_pkg::VAL_W-2:0], fits};
        end
    end

endmodule

// ----- rtl/core/ssrs_back.sv -----
module ssrs_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  ssrs_pkg::entry_t                   q_entry,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ssrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser
);

    ssrs_pkg::state_t state_reg, state_next;

    logic [ssrs_pkg::VAL_W-1:0]   mem [ssrs_pkg::MAX_SAMPLES];
    logic [ssrs_pkg::VAL_W-1:0]   rdata_reg;
    logic [ssrs_pkg::IDX_W-1:0]   rd_addr;
    logic                         rd_en, scanning, issue_done, scan_done;

    logic [ssrs_pkg::CNT_W-1:0]   n_reg, iss_reg, cand_idx_reg, lt_reg, le_reg;
    logic                         rv_reg, pv_reg, err_reg;
    logic [ssrs_pkg::VAL_W-1:0]   query_reg, cand_reg, med_lo_reg, med_hi_reg, mean_reg;
    logic [ssrs_pkg::RCNT_W-1:0]  rank_reg;
    logic [ssrs_pkg::SUM_W-1:0]   sum_reg;
    logic [ssrs_pkg::CNT_W-1:0]   rem_reg, b_reg;
    logic [ssrs_pkg::SQ_W-1:0]    prod_reg, var_reg;
    logic [ssrs_pkg::S2_W-1:0]    s2_reg, a_reg;
    logic [2*ssrs_pkg::CNT_W-1:0] bn_reg, rr_reg;
    logic [ssrs_pkg::CNT_W-1:0]   lo_pos, hi_pos;
    logic [ssrs_pkg::VAL_W-1:0]   diff;
    logic [ssrs_pkg::VAL_W:0]     med_sum;

    logic                         out_valid_reg, out_err_reg;
    logic [ssrs_pkg::RANK_W-1:0]  out_rank_reg;
    logic [ssrs_pkg::VAL_W-1:0]   out_mean_reg, out_med_reg, out_std_reg;
    logic                         out_free;

    logic                         div_start, div_done, sqrt_start, sqrt_done;
    logic [ssrs_pkg::DIV_W-1:0]   div_dividend, div_quo;
    logic [ssrs_pkg::CNT_W-1:0]   div_rem;
    logic [ssrs_pkg::VAL_W-1:0]   sqrt_root;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign scanning   = (state_reg == ssrs_pkg::ST_SCAN1) ||
                        (state_reg == ssrs_pkg::ST_MSCAN) ||
                        (state_reg == ssrs_pkg::ST_SCAN2);
    assign issue_done = (iss_reg == n_reg);
    assign scan_done  = issue_done && !rv_reg && !pv_reg;
    assign lo_pos     = (n_reg - 1'b1) >> 1;
    assign hi_pos     = n_reg >> 1;
    assign diff       = (rdata_reg >= mean_reg) ? rdata_reg - mean_reg : mean_reg - rdata_reg;
    assign med_sum    = {1'b0, med_lo_reg} + {1'b0, med_hi_reg};
    assign div_dividend = (state_reg == ssrs_pkg::ST_DIV1) ?
                          ssrs_pkg::DIV_W'(sum_reg) : s2_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssrs_pkg::ST_IDLE: begin
                if (q_valid && q_entry.op == ssrs_pkg::OP_FINISH) begin
                    state_next = (n_reg == '0) ? ssrs_pkg::ST_OUT : ssrs_pkg::ST_SCAN1;
                end
            end
            ssrs_pkg::ST_SCAN1: if (scan_done) state_next = ssrs_pkg::ST_MLOAD;
            ssrs_pkg::ST_MLOAD: state_next = ssrs_pkg::ST_MCAND;
            ssrs_pkg::ST_MCAND: state_next = ssrs_pkg::ST_MSCAN;
            ssrs_pkg::ST_MSCAN: begin
                if (scan_done) begin
                    state_next = (cand_idx_reg == n_reg - 1'b1) ?
                                 ssrs_pkg::ST_DIV1 : ssrs_pkg::ST_MLOAD;
                end
            end
            ssrs_pkg::ST_DIV1:  state_next = ssrs_pkg::ST_DIV1W;
            ssrs_pkg::ST_DIV1W: if (div_done) state_next = ssrs_pkg::ST_SCAN2;
            ssrs_pkg::ST_SCAN2: if (scan_done) state_next = ssrs_pkg::ST_DIV2;
            ssrs_pkg::ST_DIV2:  state_next = ssrs_pkg::ST_DIV2W;
            ssrs_pkg::ST_DIV2W: if (div_done) state_next = ssrs_pkg::ST_CMP;
            ssrs_pkg::ST_CMP:   state_next = ssrs_pkg::ST_CMP2;
            ssrs_pkg::ST_CMP2:  state_next = ssrs_pkg::ST_SQRT;
            ssrs_pkg::ST_SQRT:  state_next = ssrs_pkg::ST_SQRTW;
            ssrs_pkg::ST_SQRTW: if (sqrt_done) state_next = ssrs_pkg::ST_OUT;
            ssrs_pkg::ST_OUT:   if (out_free) state_next = ssrs_pkg::ST_IDLE;
            default:            state_next = ssrs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready    = (state_reg == ssrs_pkg::ST_IDLE);
        div_start  = (state_reg == ssrs_pkg::ST_DIV1) || (state_reg == ssrs_pkg::ST_DIV2);
        sqrt_start = (state_reg == ssrs_pkg::ST_SQRT);
        rd_en      = (scanning && !issue_done) || (state_reg == ssrs_pkg::ST_MLOAD);
        rd_addr    = (state_reg == ssrs_pkg::ST_MLOAD) ? cand_idx_reg[ssrs_pkg::IDX_W-1:0]
                                                       : iss_reg[ssrs_pkg::IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && q_entry.op == ssrs_pkg::OP_ADD) begin
            mem[n_reg[ssrs_pkg::IDX_W-1:0]] <= q_entry.value;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ssrs_pkg::ST_IDLE;
            n_reg         <= '0;
            rv_reg        <= 1'b0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rd_en && (state_reg != ssrs_pkg::ST_MLOAD);
            pv_reg    <= rv_reg && (state_reg == ssrs_pkg::ST_SCAN2);
            // keep the count through the finish, empty the set once the result is out
            if (q_valid && q_ready && q_entry.op == ssrs_pkg::OP_ADD) begin
                n_reg <= n_reg + 1'b1;
            end
            if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ssrs_pkg::ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
                n_reg         <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en && state_reg != ssrs_pkg::ST_MLOAD) begin
            iss_reg <= iss_reg + 1'b1;
        end
        unique case (state_reg)
            ssrs_pkg::ST_IDLE: begin
                query_reg    <= q_entry.value;
                err_reg      <= (n_reg == '0);
                iss_reg      <= '0;
                rank_reg     <= '0;
                sum_reg      <= '0;
                cand_idx_reg <= '0;
            end
            ssrs_pkg::ST_SCAN1: begin
                if (rv_reg) begin
                    if (query_reg > rdata_reg) begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                    sum_reg <= sum_reg + ssrs_pkg::SUM_W'(rdata_reg);
                end
            end
            ssrs_pkg::ST_MCAND: begin
                cand_reg <= rdata_reg;
                iss_reg  <= '0;
                lt_reg   <= '0;
                le_reg   <= '0;
            end
            ssrs_pkg::ST_MSCAN: begin
                if (rv_reg) begin
                    if (rdata_reg < cand_reg) lt_reg <= lt_reg + 1'b1;
                    if (rdata_reg <= cand_reg) le_reg <= le_reg + 1'b1;
                end
                if (scan_done) begin
                    // place the candidate by its rank among all samples
                    if (lt_reg <= lo_pos && lo_pos < le_reg) med_lo_reg <= cand_reg;
                    if (lt_reg <= hi_pos && hi_pos < le_reg) med_hi_reg <= cand_reg;
                    cand_idx_reg <= cand_idx_reg + 1'b1;
                end
            end
            ssrs_pkg::ST_DIV1W: begin
                mean_reg <= div_quo[ssrs_pkg::VAL_W-1:0];
                rem_reg  <= div_rem;
                iss_reg  <= '0;
                s2_reg   <= '0;
            end
            ssrs_pkg::ST_SCAN2: begin
                if (rv_reg) prod_reg <= diff * diff;
                if (pv_reg) s2_reg <= s2_reg + ssrs_pkg::S2_W'(prod_reg);
            end
            ssrs_pkg::ST_DIV2W: begin
                a_reg <= div_quo;
                b_reg <= div_rem;
            end
            ssrs_pkg::ST_CMP: begin
                bn_reg <= b_reg * n_reg;
                rr_reg <= rem_reg * rem_reg;
            end
            ssrs_pkg::ST_CMP2: begin
                // correct the variance for the remainder of the mean
                var_reg <= ssrs_pkg::SQ_W'(a_reg - ssrs_pkg::S2_W'(bn_reg < rr_reg));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ssrs_pkg::ST_OUT && out_free) begin
            out_err_reg  <= err_reg;
            out_rank_reg <= err_reg ? '0 : rank_reg[ssrs_pkg::RANK_W-1:0];
            out_mean_reg <= err_reg ? '0 : mean_reg;
            out_med_reg  <= err_reg ? '0 : med_sum[ssrs_pkg::VAL_W:1];
            out_std_reg  <= err_reg ? '0 : sqrt_root;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_std_reg, out_med_reg, out_mean_reg, out_rank_reg};
    assign m_axis_tuser  = out_err_reg;

    ssrs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (n_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    ssrs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (var_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

endmodule

// ----- rtl/core/sample_set_rank_statistics_unit.sv -----
// Sample set statistics. Add transactions (tuser 0) load a Q8.16 sample into
// a 128-entry store, one per cycle while the input queue is not full; adds
// beyond capacity are accepted and dropped. A finish transaction (tuser 1)
// carries a query and yields one result: rank of the query, truncated mean,
// median and floor population standard deviation; the store is then emptied.
// An empty finish returns zeros with the error flag set. A finish runs the
// median selection on the single read port of the sample store, two passes
// of the shared serial divider and the square root, and its result may then
// wait on the output. A four-entry queue buffers incoming transactions
// meanwhile.
module sample_set_rank_statistics_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ssrs_pkg::VAL_W-1:0]         s_axis_tdata,  // sample_value
    input  logic                               s_axis_tuser,  // opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // rank_count, mean_value, median_value, std_dev
    output logic [ssrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tuser   // empty_error
);

    logic             q_valid, q_ready;
    ssrs_pkg::entry_t q_entry;

    ssrs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_entry       (q_entry)
    );

    ssrs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_entry       (q_entry),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import ssrs_pkg::*;

    typedef struct packed {
        logic             flag;
        logic [VAL_W-1:0] sdev;
        logic [VAL_W-1:0] median;
        logic [VAL_W-1:0] mean;
        logic [RANK_W-1:0] rank;
    } stats_t;

    // Tracks the loaded set and the queue of statistics still owed by the block.
    class stats_board;
        logic [VAL_W-1:0] samples[$];
        stats_t           owed[$];
        int               errors;

        function void note_item(logic op, logic [VAL_W-1:0] value);
            stats_t           r;
            logic [VAL_W-1:0] srt[$];
            longint unsigned  sum, sumsq, n, var_q, root, bitv;
            int               rank;
            if (op == OP_ADD) begin
                if (samples.size() < MAX_SAMPLES) samples = {samples, value};
                return;
            end
            r = '0;
            n = samples.size();
            if (n == 0) begin
                r.flag = 1'b1;
            end else begin
                srt = samples;
                srt.sort();
                rank = 0;
                sum = 0;
                sumsq = 0;
                foreach (srt[i]) begin
                    if (srt[i] < value) rank++;
                    sum += srt[i];
                end
                r.rank = rank[RANK_W-1:0];
                r.mean = VAL_W'(sum / n);
                if (n % 2) r.median = srt[n/2];
                else r.median = VAL_W'((longint'(srt[n/2-1]) + srt[n/2]) >> 1);
                // variance via deviations from the truncated mean to stay in 64 bits
                foreach (srt[i]) begin
                    longint d;
                    d = longint'(srt[i]) - longint'(r.mean);
                    sumsq += (d < 0 ? -d : d) * (d < 0 ? -d : d);
                end
                var_q = sumsq / n;
                if ((sumsq % n) * n < (sum % n) * (sum % n)) var_q--;
                root = 0;
                for (int b = 31; b >= 0; b--) begin
                    bitv = root | (64'd1 << b);
                    if (bitv * bitv <= var_q) root = bitv;
                end
                r.sdev = root[VAL_W-1:0];
            end
            samples.delete();
            owed = {owed, r};
        endfunction

        task check_result(stats_t got);
            stats_t e;
            if (owed.size() == 0) begin
                report("result with nothing owed");
                return;
            end
            e = owed.pop_front();
            if (got.rank != e.rank) report($sformatf("rank %0d exp %0d", got.rank, e.rank));
            if (got.mean != e.mean) report($sformatf("mean %h exp %h", got.mean, e.mean));
            if (got.median != e.median)
                report($sformatf("median %h exp %h", got.median, e.median));
            if (got.sdev != e.sdev) report($sformatf("stddev %h exp %h", got.sdev, e.sdev));
            if (got.flag != e.flag) report($sformatf("error flag %b exp %b", got.flag, e.flag));
        endtask

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [VAL_W-1:0]      s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    stats_board board = new();
    longint     cycles = 0;
    bit         hold_sink = 1'b0;
    bit         sending_done = 1'b0;

    always #5 aclk = ~aclk;

    sample_set_rank_statistics_unit i_dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: check on handshake, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result({m_axis_tuser, m_axis_tdata});
        m_axis_tready <= !hold_sink && (($urandom_range(0, 3) != 0) || cycles % 400 < 100);
    end

    // Long receiver stall while short sets keep arriving, so the queue fills up.
    initial begin
        repeat (22000) @(posedge aclk);
        hold_sink <= 1'b1;
        repeat (2000) @(posedge aclk);
        hold_sink <= 1'b0;
    end

    int burst = 0;

    task automatic send(logic op, logic [VAL_W-1:0] value);
        int gap;
        if (burst == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst = $urandom_range(1, 12);
        end
        burst--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= value;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_item(op, value);
    endtask

    function automatic logic [VAL_W-1:0] rnd_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return VAL_W'($urandom_range(0, 255));
            default: return VAL_W'($urandom());
        endcase
    endfunction

    initial begin
        int items, n;
        logic [VAL_W-1:0] v;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: empty finish, single extremes, even and odd sets, ties
        send(OP_FINISH, '1);
        send(OP_ADD, '1);
        send(OP_FINISH, '1);
        send(OP_ADD, '0);
        send(OP_ADD, '1);
        send(OP_FINISH, '1);
        send(OP_ADD, 24'h5);
        send(OP_ADD, 24'h5);
        send(OP_ADD, 24'h1);
        send(OP_FINISH, 24'h5);
        send(OP_ADD, 24'h10000);
        send(OP_ADD, 24'haaaaaa);
        send(OP_ADD, 24'h555555);
        send(OP_ADD, 24'h3);
        send(OP_FINISH, '0);
        send(OP_FINISH, 24'h0);
        items = 16;
        // full store with overflow adds; query equal to the largest sample
        for (int i = 0; i < MAX_SAMPLES + 3; i++) send(OP_ADD, (i == 5) ? '1 : rnd_value());
        send(OP_FINISH, '1);
        items += MAX_SAMPLES + 4;
        while (items < 1050) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                send(OP_ADD, rnd_value());
            end
            v = rnd_value();
            send(OP_FINISH, v);
            items += n + 1;
        end
        s_axis_tvalid <= 1'b0;
        while (board.owed.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (board.errors == 0 && board.samples.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
